// ===== design/psu_pkg.sv =====
// Shared constants, types and the Paeth predictor for the PNG scanline unfilter.
package psu_pkg;

  localparam int MAX_LINE_BYTES  = 8192;
  localparam int MAX_PIXEL_BYTES = 8;
  localparam int COL_W           = $clog2(MAX_LINE_BYTES);
  localparam int WIN_IDX_W       = $clog2(MAX_PIXEL_BYTES);
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] REG_PIXEL_BYTES = 2'd0;
  localparam logic [1:0] REG_LINE_BYTES  = 2'd1;
  localparam logic [1:0] REG_IMAGE_ROWS  = 2'd2;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4,
    FILT_BAD   = 3'd5
  } filt_t;

  typedef struct packed {
    logic [7:0]       data;
    logic [COL_W-1:0] col;
    filt_t            filt;
    logic             first_row;
    logic             row_end;
    logic             image_end;
  } work_item_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
    logic       image_end;
    logic       bad;
  } result_t;

  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [9:0] dbc;
    logic signed [9:0] dac;
    logic signed [9:0] dsum;
    logic [9:0]        pa;
    logic [9:0]        pb;
    logic [9:0]        pc;
    dbc  = $signed({2'b00, b}) - $signed({2'b00, c});
    dac  = $signed({2'b00, a}) - $signed({2'b00, c});
    dsum = dbc + dac;
    pa   = dbc[9]  ? 10'(-dbc)  : 10'(dbc);
    pb   = dac[9]  ? 10'(-dac)  : 10'(dac);
    pc   = dsum[9] ? 10'(-dsum) : 10'(dsum);
    if (pa <= pb && pa <= pc) begin
      paeth_pick = a;
    end else if (pb <= pc) begin
      paeth_pick = b;
    end else begin
      paeth_pick = c;
    end
  endfunction

endpackage

// ===== design/png_scanline_unfilter.sv =====
// PNG scanline unfilter: top level with configuration registers.
//
// Input channel: a byte is transferred on a clock edge with push high and full
// low. The first byte of each row is the filter type and gives no result; the
// next line_bytes bytes each give one reconstructed byte.
// Result channel: while empty is low, pixel_byte, row_end, image_end and
// bad_filter show the oldest result; it is transferred on an edge with pop high.
// Configuration: wr_en with wr_index 0 (pixel_bytes), 1 (line_bytes) or
// 2 (image_rows) writes wr_data at that edge; other indexes are ignored.
// Write only while no byte is in flight.
// Path: work queue, reconstruction stage register, result queue.
// Throughput: one byte per cycle while results are popped; prior-row memory
// is read on entry to the stage, written by it: one read, one write a cycle.
// A stalled receiver fills the four-entry result queue, then the four-entry
// work queue, after which full rises; nothing is dropped.
// Reset (rst, synchronous) empties both queues, restores pixel_bytes 3,
// line_bytes 3, image_rows 1 and expects a filter type next.
module png_scanline_unfilter import psu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  pixel_byte,
  output logic        row_end,
  output logic        image_end,
  output logic        bad_filter,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data
);

  logic [3:0]  pixel_bytes;
  logic [13:0] line_bytes;
  logic [15:0] image_rows;

  logic       q_push;
  work_item_t q_in;
  logic       q_full;
  logic       q_pop;
  work_item_t q_head;
  logic       q_empty;
  result_t    result;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_bytes <= 4'd3;
      line_bytes  <= 14'd3;
      image_rows  <= 16'd1;
    end else if (wr_en) begin
      case (wr_index)
        REG_PIXEL_BYTES: pixel_bytes <= wr_data[3:0];
        REG_LINE_BYTES:  line_bytes  <= wr_data[13:0];
        REG_IMAGE_ROWS:  image_rows  <= wr_data;
        default: ;
      endcase
    end
  end

  psu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .data_byte  (data_byte),
    .full       (full),
    .line_bytes (line_bytes),
    .image_rows (image_rows),
    .q_push     (q_push),
    .q_item     (q_in),
    .q_full     (q_full)
  );

  psu_work_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .item_in (q_in),
    .full    (q_full),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty)
  );

  psu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pixel_bytes (pixel_bytes),
    .q_item      (q_head),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_pop     (pop),
    .out_empty   (empty),
    .result      (result)
  );

  assign pixel_byte = result.pixel;
  assign row_end    = result.row_end;
  assign image_end  = result.image_end;
  assign bad_filter = result.bad;

endmodule

// ===== design/psu_front.sv =====
// Front end: takes input bytes, tracks row and column, tags samples for the back end.
module psu_front import psu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [7:0]  data_byte,
  output logic        full,
  input  logic [13:0] line_bytes,
  input  logic [15:0] image_rows,
  output logic        q_push,
  output work_item_t  q_item,
  input  logic        q_full
);

  logic             awaiting;
  filt_t            filt;
  logic [COL_W-1:0] col;
  logic [15:0]      row_num;

  logic        in_fire;
  logic [13:0] lb_eff;
  logic [15:0] rows_eff;
  logic [13:0] col_inc;
  logic [16:0] row_inc;
  logic        row_end;
  logic        image_end;

  assign full    = q_full;
  assign in_fire = push && !q_full;

  always_comb begin
    if (line_bytes == 14'd0) begin
      lb_eff = 14'd1;
    end else if (line_bytes > 14'(MAX_LINE_BYTES)) begin
      lb_eff = 14'(MAX_LINE_BYTES);
    end else begin
      lb_eff = line_bytes;
    end
    rows_eff  = (image_rows == 16'd0) ? 16'd1 : image_rows;
    col_inc   = {1'b0, col} + 14'd1;
    row_inc   = {1'b0, row_num} + 17'd1;
    row_end   = col_inc >= lb_eff;
    image_end = row_end && (row_inc >= {1'b0, rows_eff});
  end

  assign q_push           = in_fire && !awaiting;
  assign q_item.data      = data_byte;
  assign q_item.col       = col;
  assign q_item.filt      = filt;
  assign q_item.first_row = (row_num == 16'd0);
  assign q_item.row_end   = row_end;
  assign q_item.image_end = image_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting <= 1'b1;
      filt     <= FILT_NONE;
      col      <= '0;
      row_num  <= '0;
    end else if (in_fire) begin
      if (awaiting) begin
        filt     <= (data_byte > 8'd4) ? FILT_BAD : filt_t'(data_byte[2:0]);
        col      <= '0;
        awaiting <= 1'b0;
      end else if (row_end) begin
        awaiting <= 1'b1;
        col      <= '0;
        row_num  <= image_end ? 16'd0 : row_inc[15:0];
      end else begin
        col <= col_inc[COL_W-1:0];
      end
    end
  end

endmodule

// ===== design/psu_work_queue.sv =====
// Short queue of tagged samples between front and back end.
module psu_work_queue import psu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  work_item_t item_in,
  output logic       full,
  input  logic       pop,
  output work_item_t head,
  output logic       empty
);

  work_item_t        store [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  logic push_ok;
  logic pop_ok;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign head    = store[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push_ok) begin
        wptr <= wptr + 1'b1;
      end
      if (pop_ok) begin
        rptr <= rptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      store[wptr] <= item_in;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("work queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push_ok && !pop_ok |=> count == $past(count) + 1'b1)
    else $error("work queue count did not follow a lone push");

endmodule

// ===== design/psu_back.sv =====
// Back end: prior-row memory, neighbour windows, filter reconstruction and result queue.
module psu_back import psu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [3:0] pixel_bytes,
  input  work_item_t q_item,
  input  logic       q_empty,
  output logic       q_pop,
  input  logic       out_pop,
  output logic       out_empty,
  output result_t    result
);

  logic [7:0]        prior_mem [MAX_LINE_BYTES];
  logic [7:0]        rdata;
  logic              s2_valid;
  work_item_t        s2;
  logic [7:0]        left_win [MAX_PIXEL_BYTES];
  logic [7:0]        ul_win [MAX_PIXEL_BYTES];

  result_t           ofifo [QUEUE_DEPTH];
  logic [QPTR_W-1:0] owptr;
  logic [QPTR_W-1:0] orptr;
  logic [QCNT_W-1:0] ocount;

  logic                 s2_fire;
  logic                 load;
  logic                 opop_ok;
  logic [3:0]           bpp_eff;
  logic [WIN_IDX_W-1:0] win_idx;
  logic                 left_ok;
  logic [7:0]           a;
  logic [7:0]           b;
  logic [7:0]           c;
  logic [8:0]           ab_sum;
  logic [7:0]           pred;
  logic [7:0]           y;

  assign s2_fire   = s2_valid && (ocount != QCNT_W'(QUEUE_DEPTH));
  assign load      = !q_empty && (!s2_valid || s2_fire);
  assign q_pop     = load;
  assign out_empty = (ocount == '0);
  assign opop_ok   = out_pop && !out_empty;
  assign result    = ofifo[orptr];

  always_comb begin
    if (pixel_bytes == 4'd0) begin
      bpp_eff = 4'd1;
    end else if (pixel_bytes > 4'(MAX_PIXEL_BYTES)) begin
      bpp_eff = 4'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = pixel_bytes;
    end
    win_idx = WIN_IDX_W'(bpp_eff - 4'd1);
    left_ok = s2.col >= COL_W'(bpp_eff);
    b       = s2.first_row ? 8'd0 : rdata;
    a       = left_ok ? left_win[win_idx] : 8'd0;
    c       = left_ok ? ul_win[win_idx] : 8'd0;
    ab_sum  = {1'b0, a} + {1'b0, b};
    case (s2.filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = ab_sum[8:1];
      FILT_PAETH: pred = paeth_pick(a, b, c);
      default:    pred = 8'd0;
    endcase
    y = s2.data + pred;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (load) begin
      s2_valid <= 1'b1;
    end else if (s2_fire) begin
      s2_valid <= 1'b0;
    end
  end

  // read with write-through when the sample above was produced this cycle
  always_ff @(posedge clk) begin
    if (load) begin
      s2    <= q_item;
      rdata <= (s2_fire && s2.col == q_item.col) ? y : prior_mem[q_item.col];
    end
    if (s2_fire) begin
      prior_mem[s2.col] <= y;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      left_win[0] <= y;
      ul_win[0]   <= b;
      for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
        left_win[i] <= left_win[i-1];
        ul_win[i]   <= ul_win[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owptr  <= '0;
      orptr  <= '0;
      ocount <= '0;
    end else begin
      if (s2_fire) begin
        owptr <= owptr + 1'b1;
      end
      if (opop_ok) begin
        orptr <= orptr + 1'b1;
      end
      if (s2_fire && !opop_ok) begin
        ocount <= ocount + 1'b1;
      end else if (opop_ok && !s2_fire) begin
        ocount <= ocount - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      ofifo[owptr].pixel     <= y;
      ofifo[owptr].row_end   <= s2.row_end;
      ofifo[owptr].image_end <= s2.image_end;
      ofifo[owptr].bad       <= (s2.filt == FILT_BAD);
    end
  end

  a_bypass: assert property (@(posedge clk) disable iff (rst)
    load && s2_fire && s2.col == q_item.col |=> rdata == $past(y))
    else $error("prior row bypass lost the fresh sample");

  a_ocount_bound: assert property (@(posedge clk) disable iff (rst)
    ocount <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue count beyond depth");

endmodule
